### design/rti_pkg.sv
// Package for the ray/triangle intersection block.
// Holds register indexes, the epsilon reset value, fixed widths and the queue status type.
package rti_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int FRAC_DEF    = 16;
  localparam int DIST_W      = 32;
  localparam int EPS_W       = 32;
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_ORG_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORG_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORG_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_DIR_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_EPS   = 3'd6;

  localparam logic [EPS_W-1:0] EPS_RESET = 32'd281474977;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

### design/ray_triangle_intersect.sv
// Ray/triangle intersection: one triangle transaction per cycle while busy is low; out_valid
// follows the accepting edge through the front register, the queue, the back end and the 32 divider stages.
// busy stays low in steady operation since the back end never waits on the receiver.
// Synchronous active-low reset clears the ray registers (epsilon to about 1e-6)
// and empties the pipeline; results are strobed on out_valid for one cycle.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int FRAC_BITS   = FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  in_vert0_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vert0_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vert0_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vert1_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vert1_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vert1_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vert2_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vert2_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vert2_z,
  input  logic                           cfg_we,
  input  logic [IDX_W-1:0]               cfg_index,
  input  logic [((COORD_WIDTH > EPS_W) ? COORD_WIDTH : EPS_W)-1:0] cfg_data,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic [DIST_W-1:0]              out_hit_distance
);

  localparam int C  = COORD_WIDTH;
  localparam int E  = C + 1;
  localparam int DW = 3 * C + 6;

  logic signed [C-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [C-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [EPS_W-1:0]    eps_r;

  q_stat_t             q_stat;
  logic                push;
  logic [9*E-1:0]      f_item;
  logic [9*E-1:0]      q_item;
  logic                b_vld, b_hit, b_ovf;
  logic [DW-1:0]       b_tn, b_adet;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= '0;
      eps_r   <= EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORG_X: org_x_r <= cfg_data[C-1:0];
        REG_ORG_Y: org_y_r <= cfg_data[C-1:0];
        REG_ORG_Z: org_z_r <= cfg_data[C-1:0];
        REG_DIR_X: dir_x_r <= cfg_data[C-1:0];
        REG_DIR_Y: dir_y_r <= cfg_data[C-1:0];
        REG_DIR_Z: dir_z_r <= cfg_data[C-1:0];
        REG_EPS:   eps_r   <= cfg_data[EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rti_front #(.C(C)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .v0_x   (in_vert0_x),
    .v0_y   (in_vert0_y),
    .v0_z   (in_vert0_z),
    .v1_x   (in_vert1_x),
    .v1_y   (in_vert1_y),
    .v1_z   (in_vert1_z),
    .v2_x   (in_vert2_x),
    .v2_y   (in_vert2_y),
    .v2_z   (in_vert2_z),
    .org_x  (org_x_r),
    .org_y  (org_y_r),
    .org_z  (org_z_r),
    .q_stat (q_stat),
    .push   (push),
    .item   (f_item)
  );

  rti_queue #(.W(9 * E)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_item),
    .pop   (1'b1),
    .dout  (q_item),
    .stat  (q_stat)
  );

  rti_back #(.C(C), .F(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_stat.valid),
    .item     (q_item),
    .dir_x    (dir_x_r),
    .dir_y    (dir_y_r),
    .dir_z    (dir_z_r),
    .eps      (eps_r),
    .out_vld  (b_vld),
    .out_hit  (b_hit),
    .out_ovf  (b_ovf),
    .out_tn   (b_tn),
    .out_adet (b_adet)
  );

  rti_div #(.DW(DW), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (b_vld),
    .in_hit    (b_hit),
    .in_ovf    (b_ovf),
    .in_tn     (b_tn),
    .in_adet   (b_adet),
    .out_valid (out_valid),
    .out_hit   (out_hit),
    .out_dist  (out_hit_distance)
  );

endmodule

### design/rti_front.sv
// Front end: takes a triangle transaction and forms edge1, edge2 and origin - vert0.
// Depends on rti_pkg for the queue status type.
module rti_front import rti_pkg::*; #(
  parameter int C = COORD_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [C-1:0]  v0_x, v0_y, v0_z,
  input  logic signed [C-1:0]  v1_x, v1_y, v1_z,
  input  logic signed [C-1:0]  v2_x, v2_y, v2_z,
  input  logic signed [C-1:0]  org_x, org_y, org_z,
  input  q_stat_t              q_stat,
  output logic                 push,
  output logic [9*(C+1)-1:0]   item
);

  localparam int E = C + 1;

  logic               vld_r;
  logic               vld_nxt;
  logic               accept;
  logic [9*E-1:0]     item_r;
  logic signed [E-1:0] e1x, e1y, e1z, e2x, e2y, e2z, rx, ry, rz;

  assign busy    = vld_r & q_stat.full;
  assign accept  = start & ~busy;
  assign push    = vld_r & ~q_stat.full;
  assign vld_nxt = accept | (vld_r & q_stat.full);
  assign item    = item_r;

  always_comb begin
    e1x = E'(v1_x) - E'(v0_x);
    e1y = E'(v1_y) - E'(v0_y);
    e1z = E'(v1_z) - E'(v0_z);
    e2x = E'(v2_x) - E'(v0_x);
    e2y = E'(v2_y) - E'(v0_y);
    e2z = E'(v2_z) - E'(v0_z);
    rx  = E'(org_x) - E'(v0_x);
    ry  = E'(org_y) - E'(v0_y);
    rz  = E'(org_z) - E'(v0_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= {e1x, e1y, e1z, e2x, e2y, e2z, rx, ry, rz};
    end
  end

endmodule

### design/rti_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
// Depends on rti_pkg for the queue status type.
module rti_queue import rti_pkg::*; #(
  parameter int W = 9 * (COORD_W_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  din,
  input  logic          pop,
  output logic [W-1:0]  dout,
  output q_stat_t       stat
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, rptr_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic         do_pop;

  assign do_pop     = pop & (cnt_r != 2'd0);
  assign stat.valid = (cnt_r != 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign dout       = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

### design/rti_back.sv
// Back end: cross products, split dot products, sign folding and the hit tests.
// Depends on rti_pkg for widths.
module rti_back import rti_pkg::*; #(
  parameter int C = COORD_W_DEF,
  parameter int F = FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [9*(C+1)-1:0]    item,
  input  logic signed [C-1:0]   dir_x, dir_y, dir_z,
  input  logic [EPS_W-1:0]      eps,
  output logic                  out_vld,
  output logic                  out_hit,
  output logic                  out_ovf,
  output logic [3*C+5:0]        out_tn,
  output logic [3*C+5:0]        out_adet
);

  localparam int E  = C + 1;
  localparam int PA = 2 * C + 1;
  localparam int PB = 2 * C + 2;
  localparam int AW = 2 * C + 2;
  localparam int BW = 2 * C + 3;
  localparam int L  = C + 1;
  localparam int PW = 2 * C + 4;
  localparam int DW = 3 * C + 6;
  localparam int NW = DW + DIST_W;

  logic signed [E-1:0]  e1 [3], e2 [3], rr [3];
  logic signed [C-1:0]  dir [3];

  logic [7:1]           vld_r;

  logic signed [PA-1:0] pa_r [6];
  logic signed [PB-1:0] pb_r [6];
  logic signed [E-1:0]  e1_1_r [3], e2_1_r [3], r_1_r [3];

  logic signed [AW-1:0] alpha_r [3];
  logic signed [BW-1:0] beta_r [3];
  logic signed [E-1:0]  e1_2_r [3], e2_2_r [3], r_2_r [3];

  logic signed [PW-1:0] dh_r [3], dl_r [3], uh_r [3], ul_r [3];
  logic signed [PW-1:0] vh_r [3], vl_r [3], th_r [3], tl_r [3];

  logic signed [DW-1:0] dp_r [3], up_r [3], vp_r [3], tp_r [3];
  logic signed [DW-1:0] det_r, un_r, vn_r, tn_r;
  logic signed [DW-1:0] adet6_r, un6_r, vn6_r, tn6_r;

  logic                 hit7_r, ovf7_r;
  logic [DW-1:0]        tn7_r, adet7_r;

  logic                 neg;
  logic [DW:0]          unvn;
  logic                 hit_c, ovf_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = item[(8-i)*E +: E];
      e2[i] = item[(5-i)*E +: E];
      rr[i] = item[(2-i)*E +: E];
    end
    dir[0] = dir_x;
    dir[1] = dir_y;
    dir[2] = dir_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    pa_r[0] <= dir[1] * e2[2];
    pa_r[1] <= dir[2] * e2[1];
    pa_r[2] <= dir[2] * e2[0];
    pa_r[3] <= dir[0] * e2[2];
    pa_r[4] <= dir[0] * e2[1];
    pa_r[5] <= dir[1] * e2[0];
    pb_r[0] <= rr[1] * e1[2];
    pb_r[1] <= rr[2] * e1[1];
    pb_r[2] <= rr[2] * e1[0];
    pb_r[3] <= rr[0] * e1[2];
    pb_r[4] <= rr[0] * e1[1];
    pb_r[5] <= rr[1] * e1[0];
    for (int i = 0; i < 3; i++) begin
      e1_1_r[i] <= e1[i];
      e2_1_r[i] <= e2[i];
      r_1_r[i]  <= rr[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      alpha_r[i] <= AW'(pa_r[2*i]) - AW'(pa_r[2*i+1]);
      beta_r[i]  <= BW'(pb_r[2*i]) - BW'(pb_r[2*i+1]);
      e1_2_r[i]  <= e1_1_r[i];
      e2_2_r[i]  <= e2_1_r[i];
      r_2_r[i]   <= r_1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dh_r[i] <= e1_2_r[i] * $signed(alpha_r[i][AW-1:L]);
      dl_r[i] <= e1_2_r[i] * $signed({1'b0, alpha_r[i][L-1:0]});
      uh_r[i] <= r_2_r[i] * $signed(alpha_r[i][AW-1:L]);
      ul_r[i] <= r_2_r[i] * $signed({1'b0, alpha_r[i][L-1:0]});
      vh_r[i] <= dir[i] * $signed(beta_r[i][BW-1:L]);
      vl_r[i] <= dir[i] * $signed({1'b0, beta_r[i][L-1:0]});
      th_r[i] <= e2_2_r[i] * $signed(beta_r[i][BW-1:L]);
      tl_r[i] <= e2_2_r[i] * $signed({1'b0, beta_r[i][L-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dp_r[i] <= (DW'(dh_r[i]) <<< L) + DW'(dl_r[i]);
      up_r[i] <= (DW'(uh_r[i]) <<< L) + DW'(ul_r[i]);
      vp_r[i] <= (DW'(vh_r[i]) <<< L) + DW'(vl_r[i]);
      tp_r[i] <= (DW'(th_r[i]) <<< L) + DW'(tl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    un_r  <= up_r[0] + up_r[1] + up_r[2];
    vn_r  <= vp_r[0] + vp_r[1] + vp_r[2];
    tn_r  <= tp_r[0] + tp_r[1] + tp_r[2];
  end

  assign neg = det_r[DW-1];

  always_ff @(posedge clk) begin
    adet6_r <= neg ? -det_r : det_r;
    un6_r   <= neg ? -un_r  : un_r;
    vn6_r   <= neg ? -vn_r  : vn_r;
    tn6_r   <= neg ? -tn_r  : tn_r;
  end

  always_comb begin
    unvn  = {1'b0, un6_r} + {1'b0, vn6_r};
    hit_c = (adet6_r != '0) &&
            ($unsigned(adet6_r) >= DW'(eps)) &&
            !un6_r[DW-1] && ($unsigned(un6_r) <= $unsigned(adet6_r)) &&
            !vn6_r[DW-1] && (unvn <= {1'b0, adet6_r}) &&
            !tn6_r[DW-1];
    ovf_c = ((NW'($unsigned(tn6_r)) << F) >= (NW'($unsigned(adet6_r)) << DIST_W));
  end

  always_ff @(posedge clk) begin
    hit7_r  <= hit_c;
    ovf7_r  <= ovf_c;
    tn7_r   <= tn6_r;
    adet7_r <= adet6_r;
  end

  assign out_vld  = vld_r[7];
  assign out_hit  = hit7_r;
  assign out_ovf  = ovf7_r;
  assign out_tn   = tn7_r;
  assign out_adet = adet7_r;

endmodule

### design/rti_div.sv
// Pipelined restoring divider for the distance, one quotient bit per stage.
// Depends on rti_pkg for the distance width.
module rti_div import rti_pkg::*; #(
  parameter int DW = 3 * COORD_W_DEF + 6,
  parameter int F  = FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic               in_hit,
  input  logic               in_ovf,
  input  logic [DW-1:0]      in_tn,
  input  logic [DW-1:0]      in_adet,
  output logic               out_valid,
  output logic               out_hit,
  output logic [DIST_W-1:0]  out_dist
);

  localparam int NW = DW + DIST_W;
  localparam int RW = DW + 1;

  logic [NW-1:0]     num;
  logic [DIST_W:0]   vld_r;
  logic              hit_r  [DIST_W+1];
  logic              ovf_r  [DIST_W+1];
  logic [DW-1:0]     adet_r [DIST_W+1];
  logic [RW-1:0]     rem_r  [DIST_W+1];
  logic [DIST_W-1:0] lo_r   [DIST_W+1];
  logic [DIST_W-1:0] q_r    [DIST_W+1];
  logic              ov_r;
  logic              oh_r;
  logic [DIST_W-1:0] od_r;

  assign num = NW'(in_tn) << F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      vld_r <= {vld_r[DIST_W-1:0], in_vld};
      ov_r  <= vld_r[DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    hit_r[0]  <= in_hit;
    ovf_r[0]  <= in_ovf;
    adet_r[0] <= in_adet;
    rem_r[0]  <= RW'(num[NW-1:DIST_W]);
    lo_r[0]   <= num[DIST_W-1:0];
    q_r[0]    <= '0;
  end

  for (genvar k = 0; k < DIST_W; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = {rem_r[k][RW-2:0], lo_r[k][DIST_W-1]};
      ge    = (trial >= {1'b0, adet_r[k]});
    end

    always_ff @(posedge clk) begin
      hit_r[k+1]  <= hit_r[k];
      ovf_r[k+1]  <= ovf_r[k];
      adet_r[k+1] <= adet_r[k];
      rem_r[k+1]  <= ge ? (trial - {1'b0, adet_r[k]}) : trial;
      lo_r[k+1]   <= lo_r[k] << 1;
      q_r[k+1]    <= {q_r[k][DIST_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    oh_r <= hit_r[DIST_W];
    if (!hit_r[DIST_W]) begin
      od_r <= '0;
    end else if (ovf_r[DIST_W]) begin
      od_r <= '1;
    end else begin
      od_r <= q_r[DIST_W];
    end
  end

  assign out_valid        = ov_r;
  assign out_hit          = oh_r;
  assign out_dist         = od_r;

endmodule

### dv/ray_triangle_intersect_tb.sv
// Self-checking testbench for ray_triangle_intersect, driven through its command port.
// Depends on rti_pkg and the block; each result is checked against a typed expected value or an
// exact wide-integer intersection predictor, over directed and then random triangles under several rays.
`timescale 1ns / 1ps

module ray_triangle_intersect_tb;
  import rti_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec_t;
  typedef logic [8:0][31:0] tri_t;
  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
  } hit_t;
  typedef struct {
    tri_t        verts;
    bit          typed;
    hit_t        want;
    bit          slow_ray;
  } row_t;

  localparam int    ONE        = 65536;
  localparam int    CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  tri_t        verts;
  logic        cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic        out_valid;
  logic        out_hit;
  logic [31:0] out_hit_distance;

  logic [5:0][31:0] ray_regs;
  logic [31:0]      eps_reg;
  hit_t             pending_hits[$];
  int               fails;
  int               cycles;
  int               idle_pct;

  ray_triangle_intersect i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_vert0_x       (verts[0]),
    .in_vert0_y       (verts[1]),
    .in_vert0_z       (verts[2]),
    .in_vert1_x       (verts[3]),
    .in_vert1_y       (verts[4]),
    .in_vert1_z       (verts[5]),
    .in_vert2_x       (verts[6]),
    .in_vert2_y       (verts[7]),
    .in_vert2_z       (verts[8]),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_distance (out_hit_distance)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic vec_t vec_of(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c);
    vec_t v;
    v.x = $signed(a);
    v.y = $signed(b);
    v.z = $signed(c);
    return v;
  endfunction

  function automatic vec_t vsub(input vec_t a, input vec_t b);
    vec_t v;
    v.x = a.x - b.x;
    v.y = a.y - b.y;
    v.z = a.z - b.z;
    return v;
  endfunction

  function automatic vec_t vcross(input vec_t a, input vec_t b);
    vec_t v;
    v.x = a.y * b.z - a.z * b.y;
    v.y = a.z * b.x - a.x * b.z;
    v.z = a.x * b.y - a.y * b.x;
    return v;
  endfunction

  function automatic wide_t vdot(input vec_t a, input vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic hit_t trace_triangle(input tri_t t);
    vec_t  p0, e1, e2, org, dir, alpha, r, beta;
    wide_t det, adet, eps, un, vn, tn, q;
    hit_t  res;
    res = '0;
    p0    = vec_of(t[0], t[1], t[2]);
    e1    = vsub(vec_of(t[3], t[4], t[5]), p0);
    e2    = vsub(vec_of(t[6], t[7], t[8]), p0);
    org   = vec_of(ray_regs[0], ray_regs[1], ray_regs[2]);
    dir   = vec_of(ray_regs[3], ray_regs[4], ray_regs[5]);
    alpha = vcross(dir, e2);
    det   = vdot(e1, alpha);
    adet  = (det < 0) ? -det : det;
    eps   = {224'd0, eps_reg};
    if (adet == 0 || adet < eps) return res;
    r  = vsub(org, p0);
    un = vdot(alpha, r);
    if (det < 0) un = -un;
    if (un < 0 || un > adet) return res;
    beta = vcross(r, e1);
    vn   = vdot(dir, beta);
    if (det < 0) vn = -vn;
    if (vn < 0 || un + vn > adet) return res;
    tn = vdot(e2, beta);
    if (det < 0) tn = -tn;
    if (tn < 0) return res;
    q = (tn <<< 16) / adet;
    res.hit      = 1'b1;
    res.distance = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected transaction: hit %0b distance %0h", out_hit, out_hit_distance);
        fails++;
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, actual %0b", want.hit, out_hit);
          fails++;
        end
        if (out_hit_distance !== want.distance) begin
          $error("hit_distance: expected %0h, actual %0h", want.distance, out_hit_distance);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_triangle_intersect_tb failed");
      $finish;
    end
  end

  task automatic send_triangle(input tri_t t, input bit typed, input hit_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    verts = t;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_hits.push_back(typed ? want : trace_triangle(t));
  endtask

  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    if (idx == REG_EPS) eps_reg = data;
    else ray_regs[idx] = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_ray(input logic [5:0][31:0] ray, input logic [31:0] eps);
    drain();
    write_reg(REG_ORG_X, ray[0]);
    write_reg(REG_ORG_Y, ray[1]);
    write_reg(REG_ORG_Z, ray[2]);
    write_reg(REG_DIR_X, ray[3]);
    write_reg(REG_DIR_Y, ray[4]);
    write_reg(REG_DIR_Z, ray[5]);
    write_reg(REG_EPS, eps);
  endtask

  function automatic logic [31:0] small_coord(input int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic tri_t random_triangle;
    tri_t t;
    int   t0;
    if ($urandom_range(99) < 30) begin
      for (int k = 0; k < 9; k++) t[k] = $urandom;
      return t;
    end
    // Place the triangle around a point on the ray, mostly in front of the origin.
    t0 = $urandom_range(12) - 2;
    for (int k = 0; k < 9; k++)
      t[k] = ray_regs[k % 3] + t0 * ray_regs[3 + k % 3] + small_coord(2 * ONE);
    return t;
  endfunction

  function automatic tri_t make_tri(input int a0, input int a1, input int a2,
                                    input int b0, input int b1, input int b2,
                                    input int c0, input int c1, input int c2);
    tri_t t;
    t[0] = a0; t[1] = a1; t[2] = a2;
    t[3] = b0; t[4] = b1; t[5] = b2;
    t[6] = c0; t[7] = c1; t[8] = c2;
    return t;
  endfunction

  initial begin
    row_t             rows[$];
    logic [5:0][31:0] ray;
    bit               slow;
    int               phase;
    int               n;

    rst_n = 1'b0; start = 1'b0; verts = '0;
    cfg_we = 1'b0; cfg_index = REG_ORG_X; cfg_data = '0;
    fails = 0; cycles = 0; idle_pct = 27;
    ray_regs = '0; eps_reg = EPS_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A ray of zero length cannot meet anything.
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0), 1'b1, '0);
    send_triangle('1, 1'b0, '0);

    rows.push_back('{make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0), 1, {1'b1, 32'd655360}, 0});
    rows.push_back('{make_tri(-ONE, -ONE, 0, 0, ONE, 0, ONE, -ONE, 0), 1, {1'b1, 32'd655360}, 0});
    rows.push_back('{make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, {1'b1, 32'd655360}, 0});
    rows.push_back('{make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0, 0});
    rows.push_back('{make_tri(-ONE, -ONE, -20 * ONE, ONE, -ONE, -20 * ONE, 0, ONE, -20 * ONE),
                     1, '0, 0});
    rows.push_back('{make_tri(4 * ONE, -ONE, 0, 6 * ONE, -ONE, 0, 5 * ONE, ONE, 0), 1, '0, 0});
    rows.push_back('{make_tri(0, -ONE, 0, 0, ONE, 0, 0, 0, ONE), 1, '0, 0});
    rows.push_back('{make_tri(-1, -1, 0, 1, -1, 0, 0, 1, 0), 1, '0, 0});
    rows.push_back('{make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, -ONE, ONE, 0), 0, '0, 0});
    rows.push_back('{make_tri(-ONE, 0, 0, ONE, 0, 0, 0, 2 * ONE, 0), 0, '0, 0});
    rows.push_back('{make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0), 0, '0, 0});
    rows.push_back('{make_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
                     0, '0, 0});
    rows.push_back('{make_tri(-ONE, -ONE, 32767 * ONE, ONE, -ONE, 32767 * ONE, 0, ONE,
                     32767 * ONE), 0, '0, 0});
    rows.push_back('{make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0), 1, {1'b1, 32'hFFFF_FFFF}, 1});
    rows.push_back('{make_tri(-ONE, -ONE, -9 * ONE, ONE, -ONE, -9 * ONE, 0, ONE, -9 * ONE),
                     0, '0, 1});

    slow = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].slow_ray != slow || i == 0) begin
        slow = rows[i].slow_ray;
        ray  = '0;
        ray[2] = -10 * ONE;
        ray[5] = slow ? 32'd1 : ONE;
        set_ray(ray, EPS_RESET);
      end
      send_triangle(rows[i].verts, rows[i].typed, rows[i].want);
    end

    for (phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 6; k++) ray[k] = small_coord(4 * ONE);
      case (phase)
        0: set_ray(ray, EPS_RESET);
        1: set_ray(ray, 32'd0);
        2: set_ray(ray, 32'hFFFF_FFFF);
        3: set_ray({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, $urandom);
        4: begin
          for (int k = 0; k < 6; k++) if ($urandom_range(1)) ray[k] = $urandom;
          set_ray(ray, $urandom_range(1) ? $urandom : $urandom_range(1000));
        end
        default: set_ray(ray, $urandom_range(ONE));
      endcase
      for (n = 0; n < 325; n++) begin
        idle_pct = (phase < 2) ? 27 : (phase < 4) ? 47 : 0;
        send_triangle(random_triangle(), 1'b0, '0);
      end
    end

    drain();
    if (fails == 0) begin
      $display("ray_triangle_intersect_tb passed");
    end else begin
      $display("ray_triangle_intersect_tb failed");
    end
    $finish;
  end

endmodule
